@@ rtl/bgcs_pkg.sv @@
// Shared constants, codes and control structs of the binomial Gray code sequencer.
package bgcs_pkg;

	localparam int MAX_ROWS  = 8;
	localparam int MAX_MULT  = 40;
	localparam int WEIGHT_W  = 48;
	localparam int ACTION_W  = 2;
	localparam int MULT_IN_W = 6;
	localparam int ANCHOR_W  = 6;
	localparam int ROW_OUT_W = 6;
	localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNT_W     = $clog2(MAX_ROWS + 1);
	localparam int MULT_W    = $clog2(MAX_MULT + 1);
	localparam int DIVR_W    = $clog2(MAX_MULT + 2);
	localparam int PROD_W    = WEIGHT_W + MULT_W;
	localparam int DCNT_W    = $clog2(PROD_W + 1);

	typedef enum logic [ACTION_W-1:0] {
		ACT_CLEAR = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_STEP  = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_EMIT,
		S_MUL,
		S_DIVS,
		S_DIV,
		S_UPD,
		S_LAST
	} state_t;

	typedef struct packed {
		logic clear;
		logic load;
		logic scan_start;
		logic scan_next;
		logic set_done;
		logic emit_move;
		logic emit_last;
		logic mul;
		logic div_start;
		logic update;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic seq_done;
		logic list_empty;
		logic can_move;
		logic scan_at_zero;
		logic div_done;
	} dp_sts_t;

endpackage

@@ rtl/bgcs_in_if.sv @@
// Input word channel: action and row multiplicity.
interface bgcs_in_if;
	logic                            valid;
	logic                            ready;
	logic [bgcs_pkg::ACTION_W-1:0]  action;
	logic [bgcs_pkg::MULT_IN_W-1:0] multiplicity;

	modport source(output valid, action, multiplicity, input ready);
	modport sink(input valid, action, multiplicity, output ready);
endinterface

@@ rtl/bgcs_out_if.sv @@
// Result word channel: weight, changing row, subtract flag and last flag.
interface bgcs_out_if;
	logic                            valid;
	logic                            ready;
	logic [bgcs_pkg::WEIGHT_W-1:0]  weight;
	logic [bgcs_pkg::ROW_OUT_W-1:0] change_row;
	logic                            subtract;
	logic                            last;

	modport source(output valid, weight, change_row, subtract, last, input ready);
	modport sink(input valid, weight, change_row, subtract, last, output ready);
endinterface

@@ rtl/bgcs_cfg_if.sv @@
// Configuration write channel carrying the anchor row count.
interface bgcs_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bgcs_pkg::ANCHOR_W-1:0] anchor_rows;

	modport source(output valid, anchor_rows, input ready);
	modport sink(input valid, anchor_rows, output ready);
endinterface

@@ rtl/bgcs_div.sv @@
// Restoring divider, one quotient bit per cycle.
module bgcs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [bgcs_pkg::PROD_W-1:0]  dividend,
	input  logic [bgcs_pkg::DIVR_W-1:0]  divisor,
	output logic [bgcs_pkg::PROD_W-1:0]  quotient,
	output logic                          done
);

	logic [bgcs_pkg::PROD_W-1:0] quo_q;
	logic [bgcs_pkg::DIVR_W-1:0] rem_q;
	logic [bgcs_pkg::DCNT_W-1:0] cnt_q;
	logic [bgcs_pkg::DIVR_W:0]   trial;
	logic [bgcs_pkg::DIVR_W:0]   diff;
	logic                         ge;

	assign trial    = {rem_q, quo_q[bgcs_pkg::PROD_W-1]};
	assign ge       = trial >= {1'b0, divisor};
	assign diff     = trial - {1'b0, divisor};
	assign quotient = quo_q;
	assign done     = (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= bgcs_pkg::DCNT_W'(bgcs_pkg::PROD_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - bgcs_pkg::DCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[bgcs_pkg::PROD_W-2:0], ge};
			rem_q <= ge ? diff[bgcs_pkg::DIVR_W-1:0] : trial[bgcs_pkg::DIVR_W-1:0];
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (cnt_q == '0))
		else $error("divider restarted while busy");

endmodule

@@ rtl/bgcs_dp.sv @@
// Datapath: row tables, weight register, multiplier, divider and result register.
module bgcs_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bgcs_pkg::cmd_t                    cmd,
	input  logic [bgcs_pkg::MULT_IN_W-1:0]   multiplicity,
	bgcs_cfg_if.sink                          cfg,
	bgcs_out_if.source                        result,
	output bgcs_pkg::dp_sts_t                 sts
);

	logic [bgcs_pkg::ANCHOR_W-1:0]  anchor_q;
	logic [bgcs_pkg::MULT_W-1:0]    mult_q [bgcs_pkg::MAX_ROWS];
	logic [bgcs_pkg::MULT_W-1:0]    k_q [bgcs_pkg::MAX_ROWS];
	logic [bgcs_pkg::MAX_ROWS-1:0]  dir_q;
	logic [bgcs_pkg::WEIGHT_W-1:0]  weight_q;
	logic [bgcs_pkg::CNT_W-1:0]     cnt_q;
	logic                            done_q;
	logic [bgcs_pkg::ROW_W-1:0]     idx_q;
	logic [bgcs_pkg::PROD_W-1:0]    prod_q;
	logic [bgcs_pkg::DIVR_W-1:0]    divisor_q;

	logic                            out_valid_q;
	logic [bgcs_pkg::WEIGHT_W-1:0]  out_weight_q;
	logic [bgcs_pkg::ROW_OUT_W-1:0] out_row_q;
	logic                            out_sub_q;
	logic                            out_last_q;

	logic [bgcs_pkg::MULT_W-1:0]    mult_sat;
	logic                            list_full;
	logic [bgcs_pkg::ROW_W-1:0]     wr_idx;
	logic [bgcs_pkg::MULT_W-1:0]    cur_n;
	logic [bgcs_pkg::MULT_W-1:0]    cur_k;
	logic                            down;
	logic                            can_move;
	logic [bgcs_pkg::MULT_W-1:0]    factor;
	logic [bgcs_pkg::DIVR_W-1:0]    divisor;
	logic [bgcs_pkg::MAX_ROWS-1:0]  hi_mask;
	logic [bgcs_pkg::PROD_W-1:0]    quotient;
	logic                            div_done;
	logic [bgcs_pkg::WEIGHT_W-1:0]  next_weight;
	logic                            out_free;

	assign mult_sat  = (multiplicity > bgcs_pkg::MULT_IN_W'(bgcs_pkg::MAX_MULT))
		? bgcs_pkg::MULT_W'(bgcs_pkg::MAX_MULT) : bgcs_pkg::MULT_W'(multiplicity);
	assign list_full = (cnt_q == bgcs_pkg::CNT_W'(bgcs_pkg::MAX_ROWS));
	assign wr_idx    = cnt_q[bgcs_pkg::ROW_W-1:0];
	assign cur_n     = mult_q[idx_q];
	assign cur_k     = k_q[idx_q];
	assign down      = !dir_q[idx_q];
	assign can_move  = down ? (cur_k != '0) : (cur_k != cur_n);
	assign factor    = down ? cur_k : (cur_n - cur_k);
	assign divisor   = down
		? bgcs_pkg::DIVR_W'(cur_n - cur_k) + bgcs_pkg::DIVR_W'(1)
		: bgcs_pkg::DIVR_W'(cur_k) + bgcs_pkg::DIVR_W'(1);

	always_comb begin
		for (int r = 0; r < bgcs_pkg::MAX_ROWS; r++) begin
			hi_mask[r] = (bgcs_pkg::ROW_W'(r) > idx_q) && (bgcs_pkg::CNT_W'(r) < cnt_q);
		end
	end

	assign next_weight = (quotient[bgcs_pkg::PROD_W-1:bgcs_pkg::WEIGHT_W] != '0)
		? '1 : quotient[bgcs_pkg::WEIGHT_W-1:0];

	assign out_free = !out_valid_q || result.ready;

	bgcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (prod_q),
		.divisor  (divisor_q),
		.quotient (quotient),
		.done     (div_done)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_q <= bgcs_pkg::ANCHOR_W'(1);
		end else if (cfg.valid) begin
			anchor_q <= cfg.anchor_rows;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q    <= '0;
			weight_q <= bgcs_pkg::WEIGHT_W'(1);
			cnt_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			if (cmd.clear) begin
				dir_q    <= '0;
				weight_q <= bgcs_pkg::WEIGHT_W'(1);
				cnt_q    <= '0;
				done_q   <= 1'b0;
			end
			if (cmd.load && !list_full) begin
				dir_q    <= '0;
				weight_q <= bgcs_pkg::WEIGHT_W'(1);
				cnt_q    <= cnt_q + bgcs_pkg::CNT_W'(1);
				done_q   <= 1'b0;
			end
			if (cmd.set_done) begin
				done_q <= 1'b1;
			end
			if (cmd.update) begin
				weight_q <= next_weight;
				dir_q    <= dir_q ^ hi_mask;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !list_full) begin
			mult_q[wr_idx] <= mult_sat;
			for (int r = 0; r < bgcs_pkg::MAX_ROWS; r++) begin
				k_q[r] <= (bgcs_pkg::ROW_W'(r) == wr_idx) ? mult_sat : mult_q[r];
			end
		end
		if (cmd.update) begin
			k_q[idx_q] <= down ? (cur_k - bgcs_pkg::MULT_W'(1))
				: (cur_k + bgcs_pkg::MULT_W'(1));
		end
		if (cmd.scan_start) begin
			idx_q <= bgcs_pkg::ROW_W'(cnt_q - bgcs_pkg::CNT_W'(1));
		end else if (cmd.scan_next) begin
			idx_q <= idx_q - bgcs_pkg::ROW_W'(1);
		end
		if (cmd.mul) begin
			prod_q    <= bgcs_pkg::PROD_W'(weight_q) * bgcs_pkg::PROD_W'(factor);
			divisor_q <= divisor;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_move || cmd.emit_last) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_move) begin
			out_weight_q <= weight_q;
			out_row_q    <= anchor_q + bgcs_pkg::ROW_OUT_W'(idx_q);
			out_sub_q    <= down;
			out_last_q   <= 1'b0;
		end else if (cmd.emit_last) begin
			out_weight_q <= weight_q;
			out_row_q    <= '0;
			out_sub_q    <= 1'b0;
			out_last_q   <= 1'b1;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.weight     = out_weight_q;
	assign result.change_row = out_row_q;
	assign result.subtract   = out_sub_q;
	assign result.last       = out_last_q;

	assign sts.out_free     = out_free;
	assign sts.seq_done     = done_q;
	assign sts.list_empty   = (cnt_q == '0);
	assign sts.can_move     = can_move;
	assign sts.scan_at_zero = (idx_q == '0);
	assign sts.div_done     = div_done;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_move || cmd.emit_last) |-> out_free)
		else $error("result register overwritten before it was taken");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> (k_q[idx_q] <= mult_q[idx_q]))
		else $error("row position moved past its limit");

endmodule

@@ rtl/bgcs_ctrl.sv @@
// Controller state machine: input acceptance, row scan, divide sequencing, result hand-off.
module bgcs_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [bgcs_pkg::ACTION_W-1:0]  action,
	input  bgcs_pkg::dp_sts_t               sts,
	output logic                            in_ready,
	output bgcs_pkg::cmd_t                  cmd
);

	bgcs_pkg::state_t state_q;
	bgcs_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bgcs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bgcs_pkg::S_IDLE: begin
				if (in_valid && (bgcs_pkg::action_t'(action) == bgcs_pkg::ACT_STEP)) begin
					if (sts.seq_done || sts.list_empty) begin
						state_d = bgcs_pkg::S_LAST;
					end else begin
						state_d = bgcs_pkg::S_SCAN;
					end
				end
			end
			bgcs_pkg::S_SCAN: begin
				if (sts.can_move) begin
					state_d = bgcs_pkg::S_EMIT;
				end else if (sts.scan_at_zero) begin
					state_d = bgcs_pkg::S_LAST;
				end
			end
			bgcs_pkg::S_EMIT: begin
				if (sts.out_free) begin
					state_d = bgcs_pkg::S_MUL;
				end
			end
			bgcs_pkg::S_MUL:  state_d = bgcs_pkg::S_DIVS;
			bgcs_pkg::S_DIVS: state_d = bgcs_pkg::S_DIV;
			bgcs_pkg::S_DIV: begin
				if (sts.div_done) begin
					state_d = bgcs_pkg::S_UPD;
				end
			end
			bgcs_pkg::S_UPD:  state_d = bgcs_pkg::S_IDLE;
			bgcs_pkg::S_LAST: begin
				if (sts.out_free) begin
					state_d = bgcs_pkg::S_IDLE;
				end
			end
			default: state_d = bgcs_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			bgcs_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (bgcs_pkg::action_t'(action))
						bgcs_pkg::ACT_CLEAR: cmd.clear = 1'b1;
						bgcs_pkg::ACT_LOAD:  cmd.load  = 1'b1;
						bgcs_pkg::ACT_STEP: begin
							if (sts.seq_done || sts.list_empty) begin
								cmd.set_done = 1'b1;
							end else begin
								cmd.scan_start = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			bgcs_pkg::S_SCAN: begin
				if (!sts.can_move) begin
					if (sts.scan_at_zero) begin
						cmd.set_done = 1'b1;
					end else begin
						cmd.scan_next = 1'b1;
					end
				end
			end
			bgcs_pkg::S_EMIT: cmd.emit_move = sts.out_free;
			bgcs_pkg::S_MUL:  cmd.mul       = 1'b1;
			bgcs_pkg::S_DIVS: cmd.div_start = 1'b1;
			bgcs_pkg::S_DIV:  ;
			bgcs_pkg::S_UPD:  cmd.update    = 1'b1;
			bgcs_pkg::S_LAST: cmd.emit_last = sts.out_free;
			default: ;
		endcase
	end

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bgcs_pkg::S_SCAN && !sts.can_move && sts.scan_at_zero) |=> sts.seq_done)
		else $error("exhausted scan did not finish the sequence");

endmodule

@@ rtl/binomial_gray_code_sequencer_top.sv @@
// Top level of the binomial-weighted reflected Gray code sequencer.
// Channels: item (sink) takes words of action and multiplicity; result (source)
// gives weight, change_row, subtract and last; cfg (sink) writes anchor_rows and
// is always ready. Each handshake moves one word on a rising edge with valid and ready.
// A clear or load word gives no result. A step word gives one result: the rows
// are scanned from the last loaded row down (at most 8 tried), then the result
// is registered and the weight update follows: a multiply state, a divider load
// state, the bit-serial divider (54 quotient bits), then an update state.
// A step that moves a row holds item low until its update is done; a step that
// finds no row to move holds it through the scan and its last result; a step
// after the sequence has finished goes straight to its last result.
// item is ready only while no step is in work; one result may wait in the output
// register while the next word is taken. If the receiver stalls, a following step
// holds before its result register load until the waiting word is taken.
// Reset clears the row list, the direction bits and the finish flag, sets the
// weight to 1 and anchor_rows to 1, and empties the output register.
module binomial_gray_code_sequencer_top (
	input logic         clk,
	input logic         arst_n,
	bgcs_in_if.sink     item,
	bgcs_out_if.source  result,
	bgcs_cfg_if.sink    cfg
);

	bgcs_pkg::cmd_t    cmd;
	bgcs_pkg::dp_sts_t sts;
	logic              in_ready;

	assign item.ready = in_ready;

	bgcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.action   (item.action),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	bgcs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.multiplicity (item.multiplicity),
		.cfg          (cfg),
		.result       (result),
		.sts          (sts)
	);

endmodule
